### rtl/lob_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lob_pkg;

  // Default sizes of the order table and of the price ladder on each side.
  localparam int MAX_ORDERS_DEF = 256;
  localparam int MAX_LEVELS_DEF = 64;

  // Command codes.
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_SET    = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_DUP       = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  // Order state codes.
  localparam logic [1:0] ORD_OPEN      = 2'd0;
  localparam logic [1:0] ORD_PARTIAL   = 2'd1;
  localparam logic [1:0] ORD_FILLED    = 2'd2;
  localparam logic [1:0] ORD_CANCELLED = 2'd3;

  localparam logic SIDE_BUY = 1'b0;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    DP_IDLE,
    DP_SCAN,
    DP_LSETUP,
    DP_LRD,
    DP_LCMP,
    DP_WENT,
    DP_LUPD,
    DP_UP_INIT,
    DP_UP_RD,
    DP_UP_WR,
    DP_INS,
    DP_DN_INIT,
    DP_DN_RD,
    DP_DN_WR,
    DP_DEL,
    DP_WAIT,
    DP_RD_BID,
    DP_RD_ASK,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] rpt_status;
    logic [1:0] rpt_state;
  } dp_ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       qty_zero;
    logic       scan_done;
    logic       ent_found;
    logic       free_found;
    logic       lf_stop;
    logic       lf_hit;
    logic       lfound;
    logic       lvl_full;
    logic       cnt_one;
    logic       up_more;
    logic       dn_more;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/lob_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lob_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  lob_pkg::dp_sts_t sts,
  output lob_pkg::dp_ctl_t ctl
);

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_LRD, S_LCMP, S_WENT, S_LUPD,
    S_UPINIT, S_UPTEST, S_UPRD, S_UPWR, S_INS,
    S_DNINIT, S_DNTEST, S_DNRD, S_DNWR, S_DEL,
    S_RPT0, S_RPT1, S_RPT2
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [1:0]       status_next;
  logic [1:0]       ostate_next;
  lob_pkg::dp_op_t  op_next;
  logic             removing;

  assign removing = (sts.cmd == lob_pkg::CMD_CANCEL) ||
                    ((sts.cmd == lob_pkg::CMD_SET) && sts.qty_zero);

  always_comb begin
    state_next  = state;
    status_next = ctl.rpt_status;
    ostate_next = ctl.rpt_state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        status_next = lob_pkg::STAT_OK;
        ostate_next = lob_pkg::ORD_OPEN;
        state_next  = S_RPT0;
        priority if (sts.cmd == lob_pkg::CMD_ADD) begin
          priority if (sts.ent_found) begin
            status_next = lob_pkg::STAT_DUP;
          end else if (!sts.free_found) begin
            status_next = lob_pkg::STAT_FULL;
          end else begin
            state_next = S_LRD;
          end
        end else if (sts.cmd == lob_pkg::CMD_CANCEL || sts.cmd == lob_pkg::CMD_SET) begin
          if (!sts.ent_found) begin
            status_next = lob_pkg::STAT_NOT_FOUND;
          end else begin
            state_next = S_LRD;
            priority if (sts.cmd == lob_pkg::CMD_CANCEL) ostate_next = lob_pkg::ORD_CANCELLED;
            else if (sts.qty_zero) ostate_next = lob_pkg::ORD_FILLED;
            else ostate_next = lob_pkg::ORD_PARTIAL;
          end
        end else begin
          state_next = S_RPT0;
        end
      end
      S_LRD: state_next = S_LCMP;
      S_LCMP: begin
        priority if (!sts.lf_stop) begin
          state_next = S_LRD;
        end else if (sts.cmd == lob_pkg::CMD_ADD && !sts.lf_hit && sts.lvl_full) begin
          status_next = lob_pkg::STAT_FULL;
          ostate_next = lob_pkg::ORD_OPEN;
          state_next  = S_RPT0;
        end else begin
          state_next = S_WENT;
        end
      end
      S_WENT: begin
        priority if (sts.cmd == lob_pkg::CMD_ADD) begin
          state_next = sts.lfound ? S_LUPD : S_UPINIT;
        end else if (removing) begin
          priority if (!sts.lfound) state_next = S_RPT0;
          else if (sts.cnt_one) state_next = S_DNINIT;
          else state_next = S_LUPD;
        end else begin
          state_next = sts.lfound ? S_LUPD : S_RPT0;
        end
      end
      S_LUPD:   state_next = S_RPT0;
      S_UPINIT: state_next = S_UPTEST;
      S_UPTEST: state_next = sts.up_more ? S_UPRD : S_INS;
      S_UPRD:   state_next = S_UPWR;
      S_UPWR:   state_next = S_UPTEST;
      S_INS:    state_next = S_RPT0;
      S_DNINIT: state_next = S_DNTEST;
      S_DNTEST: state_next = sts.dn_more ? S_DNRD : S_DEL;
      S_DNRD:   state_next = S_DNWR;
      S_DNWR:   state_next = S_DNTEST;
      S_DEL:    state_next = S_RPT0;
      S_RPT0:   state_next = S_RPT1;
      S_RPT1:   state_next = S_RPT2;
      S_RPT2:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_next)
      S_IDLE:   op_next = lob_pkg::DP_IDLE;
      S_SCAN:   op_next = lob_pkg::DP_SCAN;
      S_DECIDE: op_next = lob_pkg::DP_LSETUP;
      S_LRD:    op_next = lob_pkg::DP_LRD;
      S_LCMP:   op_next = lob_pkg::DP_LCMP;
      S_WENT:   op_next = lob_pkg::DP_WENT;
      S_LUPD:   op_next = lob_pkg::DP_LUPD;
      S_UPINIT: op_next = lob_pkg::DP_UP_INIT;
      S_UPRD:   op_next = lob_pkg::DP_UP_RD;
      S_UPWR:   op_next = lob_pkg::DP_UP_WR;
      S_INS:    op_next = lob_pkg::DP_INS;
      S_DNINIT: op_next = lob_pkg::DP_DN_INIT;
      S_DNRD:   op_next = lob_pkg::DP_DN_RD;
      S_DNWR:   op_next = lob_pkg::DP_DN_WR;
      S_DEL:    op_next = lob_pkg::DP_DEL;
      S_RPT0:   op_next = lob_pkg::DP_RD_BID;
      S_RPT1:   op_next = lob_pkg::DP_RD_ASK;
      S_RPT2:   op_next = lob_pkg::DP_OUT;
      default:  op_next = lob_pkg::DP_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      ctl.op         <= lob_pkg::DP_IDLE;
      ctl.rpt_status <= lob_pkg::STAT_OK;
      ctl.rpt_state  <= lob_pkg::ORD_OPEN;
    end else begin
      state          <= state_next;
      ctl.op         <= op_next;
      ctl.rpt_status <= status_next;
      ctl.rpt_state  <= ostate_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

### rtl/lob_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lob_datapath #(
  parameter int MAX_ORDERS = lob_pkg::MAX_ORDERS_DEF,
  parameter int MAX_LEVELS = lob_pkg::MAX_LEVELS_DEF,
  localparam int CW = $clog2(MAX_ORDERS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  lob_pkg::dp_ctl_t    ctl,
  output lob_pkg::dp_sts_t    sts,
  input  logic [1:0]          command,
  input  logic [63:0]         ord_id,
  input  logic                side,
  input  logic signed [31:0]  price,
  input  logic [31:0]         quantity,
  output logic                done,
  output logic [1:0]          status,
  output logic [1:0]          order_state,
  output logic                best_bid_valid,
  output logic signed [31:0]  bid_price,
  output logic [31:0]         best_bid_qty,
  output logic [CW-1:0]       best_bid_count,
  output logic                best_ask_valid,
  output logic signed [31:0]  ask_price,
  output logic [31:0]         best_ask_qty,
  output logic [CW-1:0]       best_ask_count,
  output logic                crossed
);

  localparam int AW     = $clog2(MAX_ORDERS);
  localparam int SW     = $clog2(MAX_ORDERS + 1);
  localparam int LAW    = $clog2(MAX_LEVELS);
  localparam int UW     = $clog2(MAX_LEVELS + 1);
  localparam int TW     = 32 + $clog2(MAX_ORDERS);
  localparam int LDEPTH = 2 * (2 ** LAW);

  // Latched command.
  logic [1:0]         cmd_r;
  logic [63:0]        id_r;
  logic               side_r;
  logic signed [31:0] price_r;
  logic [31:0]        qty_r;

  // Order table.
  logic [MAX_ORDERS-1:0] valid;
  logic [63:0]           ent_key   [MAX_ORDERS];
  logic                  ent_side  [MAX_ORDERS];
  logic signed [31:0]    ent_price [MAX_ORDERS];
  logic [31:0]           ent_rem   [MAX_ORDERS];
  logic [63:0]           rd_key;
  logic                  rd_side;
  logic signed [31:0]    rd_price;
  logic [31:0]           rd_rem;

  // Scan state.
  logic [SW-1:0]      sc;
  logic               sdv;
  logic               sv_d;
  logic [AW-1:0]      sidx_d;
  logic               ent_found;
  logic               free_found;
  logic [AW-1:0]      f_idx;
  logic               f_side;
  logic signed [31:0] f_price;
  logic [31:0]        f_rem;
  logic [AW-1:0]      free_idx;

  // Price ladders, both sides in one store addressed by {side, level}.
  logic signed [31:0] lv_price [LDEPTH];
  logic [TW-1:0]      lv_total [LDEPTH];
  logic [CW-1:0]      lv_cnt   [LDEPTH];
  logic signed [31:0] lvq_price;
  logic [TW-1:0]      lvq_total;
  logic [CW-1:0]      lvq_cnt;
  logic [UW-1:0]      bid_used;
  logic [UW-1:0]      ask_used;
  logic               lside;
  logic signed [31:0] lprice;
  logic [UW-1:0]      lk;
  logic               lfound;
  logic [UW-1:0]      sm;

  logic [UW-1:0]      used_sel;
  logic               lk_in;
  logic               price_eq;
  logic               beyond;
  logic               lf_hit;
  logic               lf_stop;
  logic [UW-1:0]      sm_dec;
  logic [UW-1:0]      sm_inc;
  logic               lv_re;
  logic [LAW:0]       lv_raddr;
  logic               lv_we;
  logic [LAW:0]       lv_waddr;
  logic signed [31:0] lv_wprice;
  logic [TW-1:0]      lv_wtotal;
  logic [CW-1:0]      lv_wcnt;
  logic [TW-1:0]      qty_ext;
  logic [TW-1:0]      rem_ext;
  logic               issue;
  logic [31:0]        lvq_sat;

  assign used_sel = lside ? ask_used : bid_used;
  assign lk_in    = lk < used_sel;
  assign price_eq = lvq_price == lprice;
  assign beyond   = (lside == lob_pkg::SIDE_BUY) ? (lprice > lvq_price) : (lprice < lvq_price);
  assign lf_hit   = lk_in && price_eq;
  assign lf_stop  = !lk_in || price_eq || beyond;
  assign sm_dec   = sm - UW'(1);
  assign sm_inc   = sm + UW'(1);
  assign qty_ext  = TW'(qty_r);
  assign rem_ext  = TW'(f_rem);
  assign issue    = (ctl.op == lob_pkg::DP_SCAN) && (sc < SW'(MAX_ORDERS));
  assign lvq_sat  = (|lvq_total[TW-1:32]) ? 32'hFFFF_FFFF : lvq_total[31:0];

  always_comb begin
    lv_re    = 1'b1;
    lv_raddr = {lside, lk[LAW-1:0]};
    unique case (ctl.op)
      lob_pkg::DP_LRD:    lv_raddr = {lside, lk[LAW-1:0]};
      lob_pkg::DP_UP_RD:  lv_raddr = {lside, sm_dec[LAW-1:0]};
      lob_pkg::DP_DN_RD:  lv_raddr = {lside, sm_inc[LAW-1:0]};
      lob_pkg::DP_RD_BID: lv_raddr = {1'b0, LAW'(0)};
      lob_pkg::DP_RD_ASK: lv_raddr = {1'b1, LAW'(0)};
      default:            lv_re    = 1'b0;
    endcase
  end

  always_comb begin
    lv_we     = 1'b1;
    lv_waddr  = {lside, sm[LAW-1:0]};
    lv_wprice = lvq_price;
    lv_wtotal = lvq_total;
    lv_wcnt   = lvq_cnt;
    unique case (ctl.op)
      lob_pkg::DP_UP_WR, lob_pkg::DP_DN_WR: begin
      end
      lob_pkg::DP_INS: begin
        lv_waddr  = {lside, lk[LAW-1:0]};
        lv_wprice = lprice;
        lv_wtotal = qty_ext;
        lv_wcnt   = CW'(1);
      end
      lob_pkg::DP_LUPD: begin
        lv_waddr = {lside, lk[LAW-1:0]};
        unique case (cmd_r)
          lob_pkg::CMD_ADD: begin
            lv_wtotal = lvq_total + qty_ext;
            lv_wcnt   = lvq_cnt + CW'(1);
          end
          lob_pkg::CMD_SET: begin
            if (qty_r == 32'd0) begin
              lv_wtotal = lvq_total - rem_ext;
              lv_wcnt   = lvq_cnt - CW'(1);
            end else begin
              lv_wtotal = lvq_total - rem_ext + qty_ext;
            end
          end
          default: begin
            lv_wtotal = lvq_total - rem_ext;
            lv_wcnt   = lvq_cnt - CW'(1);
          end
        endcase
      end
      default: lv_we = 1'b0;
    endcase
  end

  // Level store.
  always_ff @(posedge clk) begin
    if (lv_we) begin
      lv_price[lv_waddr] <= lv_wprice;
      lv_total[lv_waddr] <= lv_wtotal;
      lv_cnt[lv_waddr]   <= lv_wcnt;
    end
    if (lv_re) begin
      lvq_price <= lv_price[lv_raddr];
      lvq_total <= lv_total[lv_raddr];
      lvq_cnt   <= lv_cnt[lv_raddr];
    end
  end

  // Order table store.
  always_ff @(posedge clk) begin
    if (ctl.op == lob_pkg::DP_WENT) begin
      if (cmd_r == lob_pkg::CMD_ADD) begin
        ent_key[free_idx]   <= id_r;
        ent_side[free_idx]  <= side_r;
        ent_price[free_idx] <= price_r;
        ent_rem[free_idx]   <= qty_r;
      end else if (cmd_r == lob_pkg::CMD_SET) begin
        ent_rem[f_idx] <= qty_r;
      end
    end
    if (issue) begin
      rd_key   <= ent_key[sc[AW-1:0]];
      rd_side  <= ent_side[sc[AW-1:0]];
      rd_price <= ent_price[sc[AW-1:0]];
      rd_rem   <= ent_rem[sc[AW-1:0]];
    end
  end

  // Command payload and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (ctl.op == lob_pkg::DP_IDLE) begin
      cmd_r      <= command;
      id_r       <= ord_id;
      side_r     <= side;
      price_r    <= price;
      qty_r      <= quantity;
      sc         <= '0;
      ent_found  <= 1'b0;
      free_found <= 1'b0;
    end
    if (issue) begin
      sc     <= sc + SW'(1);
      sv_d   <= valid[sc[AW-1:0]];
      sidx_d <= sc[AW-1:0];
    end
    if (sdv) begin
      if (sv_d && rd_key == id_r) begin
        ent_found <= 1'b1;
        f_idx     <= sidx_d;
        f_side    <= rd_side;
        f_price   <= rd_price;
        f_rem     <= rd_rem;
      end
      if (!sv_d && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= sidx_d;
      end
    end
    if (ctl.op == lob_pkg::DP_LSETUP) begin
      lside  <= (cmd_r == lob_pkg::CMD_ADD) ? side_r : f_side;
      lprice <= (cmd_r == lob_pkg::CMD_ADD) ? price_r : f_price;
      lk     <= '0;
    end
    if (ctl.op == lob_pkg::DP_LCMP) begin
      lfound <= lf_hit;
      if (!lf_stop) lk <= lk + UW'(1);
    end
    if (ctl.op == lob_pkg::DP_UP_INIT) sm <= used_sel;
    if (ctl.op == lob_pkg::DP_UP_WR) sm <= sm_dec;
    if (ctl.op == lob_pkg::DP_DN_INIT) sm <= lk;
    if (ctl.op == lob_pkg::DP_DN_WR) sm <= sm_inc;
  end

  // Control state: entry valid bits, ladder depths, result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      bid_used <= '0;
      ask_used <= '0;
      sdv      <= 1'b0;
      done     <= 1'b0;
    end else begin
      sdv  <= issue;
      done <= (ctl.op == lob_pkg::DP_OUT);
      if (ctl.op == lob_pkg::DP_WENT) begin
        if (cmd_r == lob_pkg::CMD_ADD) valid[free_idx] <= 1'b1;
        else if (cmd_r == lob_pkg::CMD_CANCEL) valid[f_idx] <= 1'b0;
        else if (cmd_r == lob_pkg::CMD_SET && qty_r == 32'd0) valid[f_idx] <= 1'b0;
      end
      if (ctl.op == lob_pkg::DP_INS) begin
        if (lside) ask_used <= ask_used + UW'(1);
        else bid_used <= bid_used + UW'(1);
      end
      if (ctl.op == lob_pkg::DP_DEL) begin
        if (lside) ask_used <= ask_used - UW'(1);
        else bid_used <= bid_used - UW'(1);
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (ctl.op == lob_pkg::DP_RD_ASK) begin
      best_bid_valid <= (bid_used != '0);
      bid_price      <= (bid_used != '0) ? lvq_price : 32'sd0;
      best_bid_qty   <= (bid_used != '0) ? lvq_sat : 32'd0;
      best_bid_count <= (bid_used != '0) ? lvq_cnt : '0;
    end
    if (ctl.op == lob_pkg::DP_OUT) begin
      best_ask_valid <= (ask_used != '0);
      ask_price      <= (ask_used != '0) ? lvq_price : 32'sd0;
      best_ask_qty   <= (ask_used != '0) ? lvq_sat : 32'd0;
      best_ask_count <= (ask_used != '0) ? lvq_cnt : '0;
      crossed        <= best_bid_valid && (ask_used != '0) && (bid_price >= lvq_price);
      status         <= ctl.rpt_status;
      order_state    <= ctl.rpt_state;
    end
  end

  assign sts.cmd        = cmd_r;
  assign sts.qty_zero   = (qty_r == 32'd0);
  assign sts.scan_done  = (sc == SW'(MAX_ORDERS)) && !sdv;
  assign sts.ent_found  = ent_found;
  assign sts.free_found = free_found;
  assign sts.lf_stop    = lf_stop;
  assign sts.lf_hit     = lf_hit;
  assign sts.lfound     = lfound;
  assign sts.lvl_full   = (used_sel == UW'(MAX_LEVELS));
  assign sts.cnt_one    = (lvq_cnt == CW'(1));
  assign sts.up_more    = (sm > lk);
  assign sts.dn_more    = (sm_inc < used_sel);

`ifndef ASSERT_OFF
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    (bid_used <= UW'(MAX_LEVELS)) && (ask_used <= UW'(MAX_LEVELS)))
    else $error("price ladder depth out of range");
  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == lob_pkg::DP_INS) |-> (used_sel < UW'(MAX_LEVELS)))
    else $error("level inserted into a full ladder");
  a_crossed_sides: assert property (@(posedge clk) disable iff (rst)
    (done && crossed) |-> (best_bid_valid && best_ask_valid))
    else $error("crossed reported with an empty side");
`endif

endmodule

`default_nettype wire

### rtl/limit_order_book.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-sided limit order book with a bounded order table and sorted price levels.
// Command channel: present command, ord_id, side, price and quantity with start
// high; the transaction is taken at the clock edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle and the status, order state,
// best bid, best ask and crossed flag are valid in that cycle. The receiver cannot
// stall; the fields are meaningful only while done is high, and the best bid fields
// update in the cycle before the strobe.
// Each transaction runs an id scan over the whole order table, one entry per
// cycle, then a level search, a level shift on insert or delete of a level,
// and a read of both top levels; the order table scan dominates.
// One transaction is in flight at a time; busy stays high until the result is out.
// Reset clears every entry valid bit and empties both price ladders at once;
// no clearing pass is needed and the block is ready on the cycle after reset.

module limit_order_book #(
  parameter int MAX_ORDERS = lob_pkg::MAX_ORDERS_DEF,
  parameter int MAX_LEVELS = lob_pkg::MAX_LEVELS_DEF,
  localparam int CW = $clog2(MAX_ORDERS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic [63:0]        ord_id,
  input  logic               side,
  input  logic signed [31:0] price,
  input  logic [31:0]        quantity,
  output logic               done,
  output logic [1:0]         status,
  output logic [1:0]         order_state,
  output logic               best_bid_valid,
  output logic signed [31:0] bid_price,
  output logic [31:0]        best_bid_qty,
  output logic [CW-1:0]      best_bid_count,
  output logic               best_ask_valid,
  output logic signed [31:0] ask_price,
  output logic [31:0]        best_ask_qty,
  output logic [CW-1:0]      best_ask_count,
  output logic               crossed
);

  // Controller sequences the scan, search, shift and report steps; the
  // datapath owns the order table, the ladders and the result registers.
  lob_pkg::dp_ctl_t ctl;
  lob_pkg::dp_sts_t sts;

  lob_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  lob_datapath #(
    .MAX_ORDERS (MAX_ORDERS),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .command        (command),
    .ord_id         (ord_id),
    .side           (side),
    .price          (price),
    .quantity       (quantity),
    .done           (done),
    .status         (status),
    .order_state    (order_state),
    .best_bid_valid (best_bid_valid),
    .bid_price      (bid_price),
    .best_bid_qty   (best_bid_qty),
    .best_bid_count (best_bid_count),
    .best_ask_valid (best_ask_valid),
    .ask_price      (ask_price),
    .best_ask_qty   (best_ask_qty),
    .best_ask_count (best_ask_count),
    .crossed        (crossed)
  );

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int N_ORD = lob_pkg::MAX_ORDERS_DEF;
  localparam int N_LVL = lob_pkg::MAX_LEVELS_DEF;
  localparam int CW = $clog2(N_ORD + 1);
  localparam int N_RANDOM = 750;
  // Command code with no operation behind it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One command transaction as presented on the input ports.
  typedef struct {
    logic [1:0]         cmd;
    logic [63:0]        id;
    logic               sd;
    logic signed [31:0] px;
    logic [31:0]        qty;
  } order_cmd_t;

  // One book snapshot as reported on the result ports.
  typedef struct {
    logic [1:0]         status;
    logic [1:0]         ostate;
    logic               bid_v;
    logic signed [31:0] bid_px;
    logic [31:0]        bid_qty;
    logic [CW-1:0]      bid_cnt;
    logic               ask_v;
    logic signed [31:0] ask_px;
    logic [31:0]        ask_qty;
    logic [CW-1:0]      ask_cnt;
    logic               crossed;
  } book_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] command = '0;
  logic [63:0] ord_id = '0;
  logic side = 1'b0;
  logic signed [31:0] price = '0;
  logic [31:0] quantity = '0;
  logic busy, done, best_bid_valid, best_ask_valid, crossed;
  logic [1:0] status, order_state;
  logic signed [31:0] bid_price, ask_price;
  logic [31:0] best_bid_qty, best_ask_qty;
  logic [CW-1:0] best_bid_count, best_ask_count;

  limit_order_book u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .ord_id(ord_id), .side(side), .price(price),
    .quantity(quantity), .done(done), .status(status), .order_state(order_state),
    .best_bid_valid(best_bid_valid), .bid_price(bid_price),
    .best_bid_qty(best_bid_qty), .best_bid_count(best_bid_count),
    .best_ask_valid(best_ask_valid), .ask_price(ask_price),
    .best_ask_qty(best_ask_qty), .best_ask_count(best_ask_count),
    .crossed(crossed)
  );

  always #5 clk = ~clk;

  // Shadow copy of the order table. Only resting orders matter: a price level
  // is exactly the set of resting orders with one side and one price, so the
  // best levels and the level occupancy are derived from the table directly.
  logic               rest_v[N_ORD];
  logic [63:0]        rest_id[N_ORD];
  logic               rest_sd[N_ORD];
  logic signed [31:0] rest_px[N_ORD];
  logic [31:0]        rest_qty[N_ORD];

  order_cmd_t pending_cmds[$];
  book_view_t expected_views[$];
  int errors = 0;
  int gap = 0;
  int quiet = 0;
  int n_checked = 0;

  function automatic order_cmd_t mk_cmd(logic [1:0] cmd, logic [63:0] id, logic sd,
                                        logic signed [31:0] px, logic [31:0] qty);
    order_cmd_t c;
    c.cmd = cmd;
    c.id = id;
    c.sd = sd;
    c.px = px;
    c.qty = qty;
    return c;
  endfunction

  function automatic int find_order(logic [63:0] id);
    for (int i = 0; i < N_ORD; i++)
      if (rest_v[i] && rest_id[i] == id) return i;
    return -1;
  endfunction

  // Number of distinct price levels currently in use on one side.
  function automatic int levels_in_use(logic sd);
    int n;
    bool_loop: begin
      n = 0;
      for (int i = 0; i < N_ORD; i++) begin
        bit seen;
        seen = 0;
        if (!rest_v[i] || rest_sd[i] != sd) continue;
        for (int j = 0; j < i; j++)
          if (rest_v[j] && rest_sd[j] == sd && rest_px[j] == rest_px[i]) seen = 1;
        if (!seen) n++;
      end
    end
    return n;
  endfunction

  // Best level of one side: highest bid or lowest ask, with the saturating
  // quantity total and the number of orders resting there.
  task automatic best_level(input logic sd, output logic v, output logic signed [31:0] px,
                            output logic [31:0] qty, output logic [CW-1:0] cnt);
    logic [32:0] sum;
    v = 0; px = '0; qty = '0; cnt = '0;
    for (int i = 0; i < N_ORD; i++)
      if (rest_v[i] && rest_sd[i] == sd)
        if (!v || (sd == lob_pkg::SIDE_BUY ? rest_px[i] > px : rest_px[i] < px)) begin
          v = 1;
          px = rest_px[i];
        end
    if (!v) return;
    sum = '0;
    for (int i = 0; i < N_ORD; i++)
      if (rest_v[i] && rest_sd[i] == sd && rest_px[i] == px) begin
        sum = sum + rest_qty[i];
        if (sum[32]) sum = 33'h0_FFFF_FFFF;
        cnt++;
      end
    qty = sum[31:0];
  endtask

  // Applies one accepted command to the shadow book and returns the view
  // that the block must report for it.
  task automatic apply_order_cmd(input order_cmd_t c, output book_view_t r);
    int idx;
    int free_idx;
    bit level_exists;
    r.status = lob_pkg::STAT_OK;
    r.ostate = lob_pkg::ORD_OPEN;
    idx = find_order(c.id);
    case (c.cmd)
      lob_pkg::CMD_ADD: begin
        if (idx >= 0) begin
          r.status = lob_pkg::STAT_DUP;
        end else begin
          free_idx = -1;
          level_exists = 0;
          for (int i = N_ORD - 1; i >= 0; i--) begin
            if (!rest_v[i]) free_idx = i;
            else if (rest_sd[i] == c.sd && rest_px[i] == c.px) level_exists = 1;
          end
          if (free_idx < 0 || (!level_exists && levels_in_use(c.sd) >= N_LVL)) begin
            r.status = lob_pkg::STAT_FULL;
          end else begin
            rest_v[free_idx] = 1;
            rest_id[free_idx] = c.id;
            rest_sd[free_idx] = c.sd;
            rest_px[free_idx] = c.px;
            rest_qty[free_idx] = c.qty;
          end
        end
      end
      lob_pkg::CMD_CANCEL: begin
        if (idx < 0) begin
          r.status = lob_pkg::STAT_NOT_FOUND;
        end else begin
          rest_v[idx] = 0;
          r.ostate = lob_pkg::ORD_CANCELLED;
        end
      end
      lob_pkg::CMD_SET: begin
        if (idx < 0) begin
          r.status = lob_pkg::STAT_NOT_FOUND;
        end else if (c.qty == 0) begin
          rest_v[idx] = 0;
          r.ostate = lob_pkg::ORD_FILLED;
        end else begin
          rest_qty[idx] = c.qty;
          r.ostate = lob_pkg::ORD_PARTIAL;
        end
      end
      default: ;
    endcase
    best_level(1'b0, r.bid_v, r.bid_px, r.bid_qty, r.bid_cnt);
    best_level(1'b1, r.ask_v, r.ask_px, r.ask_qty, r.ask_cnt);
    r.crossed = r.bid_v && r.ask_v && (r.bid_px >= r.ask_px);
  endtask

  // Driver: takes commands from the pending queue, holds start until the
  // transaction is taken, then idles for a randomly drawn number of cycles.
  // Occasionally a quiet stretch forces back-to-back transactions.
  always @(posedge clk) begin
    book_view_t v;
    if (rst) begin
      start <= 1'b0;
      gap <= 0;
    end else if (start && !busy) begin
      apply_order_cmd(mk_cmd(command, ord_id, side, price, quantity), v);
      expected_views.insert(expected_views.size(), v);
      start <= 1'b0;
      if (quiet > 0) begin
        quiet <= quiet - 1;
        gap <= 0;
      end else begin
        if ($urandom_range(0, 39) == 0) quiet <= 25;
        gap <= $urandom_range(0, 18);
      end
    end else if (!start) begin
      if (gap > 0) begin
        gap <= gap - 1;
      end else if (pending_cmds.size() > 0) begin
        order_cmd_t c;
        c = pending_cmds.pop_front();
        command <= c.cmd;
        ord_id <= c.id;
        side <= c.sd;
        price <= c.px;
        quantity <= c.qty;
        start <= 1'b1;
      end
    end
  end

  // Monitor: every done pulse is one result transaction, checked against the
  // oldest expected book view.
  always @(posedge clk) begin
    book_view_t e;
    if (!rst && done) begin
      n_checked++;
      if (expected_views.size() == 0) begin
        $error("result with no command outstanding");
        errors++;
      end else begin
        e = expected_views.pop_front();
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); errors++;
        end
        if (order_state !== e.ostate) begin
          $error("order_state exp %0d got %0d", e.ostate, order_state); errors++;
        end
        if (best_bid_valid !== e.bid_v) begin
          $error("best_bid_valid exp %0d got %0d", e.bid_v, best_bid_valid); errors++;
        end
        if (bid_price !== e.bid_px) begin
          $error("bid_price exp %0d got %0d", e.bid_px, bid_price); errors++;
        end
        if (best_bid_qty !== e.bid_qty) begin
          $error("best_bid_qty exp %0d got %0d", e.bid_qty, best_bid_qty); errors++;
        end
        if (best_bid_count !== e.bid_cnt) begin
          $error("best_bid_count exp %0d got %0d", e.bid_cnt, best_bid_count); errors++;
        end
        if (best_ask_valid !== e.ask_v) begin
          $error("best_ask_valid exp %0d got %0d", e.ask_v, best_ask_valid); errors++;
        end
        if (ask_price !== e.ask_px) begin
          $error("ask_price exp %0d got %0d", e.ask_px, ask_price); errors++;
        end
        if (best_ask_qty !== e.ask_qty) begin
          $error("best_ask_qty exp %0d got %0d", e.ask_qty, best_ask_qty); errors++;
        end
        if (best_ask_count !== e.ask_cnt) begin
          $error("best_ask_count exp %0d got %0d", e.ask_cnt, best_ask_count); errors++;
        end
        if (crossed !== e.crossed) begin
          $error("crossed exp %0d got %0d", e.crossed, crossed); errors++;
        end
      end
    end
  end

  // Picks the id of some resting order, or a fresh random id if none rests.
  function automatic logic [63:0] some_resting_id();
    int base;
    base = $urandom_range(0, N_ORD - 1);
    for (int k = 0; k < N_ORD; k++)
      if (rest_v[(base + k) % N_ORD]) return rest_id[(base + k) % N_ORD];
    return {$urandom, $urandom};
  endfunction

  function automatic order_cmd_t random_cmd(int add_weight);
    order_cmd_t c;
    int roll;
    roll = $urandom_range(0, 99);
    c.sd = $urandom_range(0, 1);
    c.id = {$urandom, $urandom};
    // A small pool of nearby prices builds deep levels; the rest spreads
    // over the full range so that the level ladders fill up.
    if ($urandom_range(0, 9) < 3) c.px = 32'sd1000 + $urandom_range(0, 7) - 4;
    else c.px = $urandom;
    c.qty = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : $urandom;
    if (roll < add_weight) begin
      c.cmd = lob_pkg::CMD_ADD;
      if ($urandom_range(0, 19) == 0) c.id = some_resting_id();
    end else begin
      c.cmd = $urandom_range(0, 1) ? lob_pkg::CMD_CANCEL : lob_pkg::CMD_SET;
      if ($urandom_range(0, 9) != 0) c.id = some_resting_id();
      if (c.cmd == lob_pkg::CMD_SET && $urandom_range(0, 3) == 0) c.qty = '0;
      if ($urandom_range(0, 49) == 0) c.cmd = CMD_UNUSED;
    end
    return c;
  endfunction

  // Stimulus: a directed opening, then an add-heavy phase that fills the
  // order table and the level ladders, then a balanced mix. Each command is
  // generated only when the previous one has left the queue, so live ids
  // are taken from a nearly up-to-date shadow book.
  initial begin
    order_cmd_t d[$];
    int n_total;
    for (int i = 0; i < N_ORD; i++) rest_v[i] = 0;
    // Unused command code on an empty book.
    d.insert(d.size(), mk_cmd(CMD_UNUSED, 64'd0, 1'b0, 32'sd0, 32'd0));
    // Zero quantity add at the lowest price, id zero.
    d.insert(d.size(), mk_cmd(lob_pkg::CMD_ADD, 64'd0, 1'b0, 32'sh8000_0000, 32'd0));
    // Largest id and quantity, highest ask price.
    d.insert(d.size(), mk_cmd(lob_pkg::CMD_ADD, '1, 1'b1, 32'sh7FFF_FFFF, '1));
    // Duplicate id, even on the other side.
    d.insert(d.size(), mk_cmd(lob_pkg::CMD_ADD, 64'd0, 1'b1, 32'sd5, 32'd9));
    // Bids at the top price cross the book; two of them saturate the level sum.
    d.insert(d.size(), mk_cmd(lob_pkg::CMD_ADD, 64'd5, 1'b0, 32'sh7FFF_FFFF, '1));
    d.insert(d.size(), mk_cmd(lob_pkg::CMD_ADD, 64'd6, 1'b0, 32'sh7FFF_FFFF, 32'd1));
    d.insert(d.size(), mk_cmd(lob_pkg::CMD_SET, 64'd6, 1'b1, 32'sd0, 32'd5));
    d.insert(d.size(), mk_cmd(lob_pkg::CMD_SET, 64'd6, 1'b0, 32'sd0, 32'd0));
    d.insert(d.size(), mk_cmd(lob_pkg::CMD_CANCEL, 64'd5, 1'b0, 32'sd0, 32'd0));
    // Unknown ids, then an unused command code on a resting id.
    d.insert(d.size(), mk_cmd(lob_pkg::CMD_CANCEL, 64'd77, 1'b0, 32'sd0, 32'd0));
    d.insert(d.size(), mk_cmd(lob_pkg::CMD_SET, 64'd77, 1'b1, 32'sd0, 32'd3));
    d.insert(d.size(), mk_cmd(CMD_UNUSED, '1, 1'b1, '1, '1));
    // Empty both sides again.
    d.insert(d.size(), mk_cmd(lob_pkg::CMD_CANCEL, 64'd0, 1'b0, 32'sd0, 32'd0));
    d.insert(d.size(), mk_cmd(lob_pkg::CMD_CANCEL, '1, 1'b1, 32'sd0, 32'd0));
    n_total = d.size() + N_RANDOM;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (d[i]) pending_cmds.insert(pending_cmds.size(), d[i]);
    for (int n = 0; n < N_RANDOM; n++) begin
      wait (pending_cmds.size() == 0);
      pending_cmds.insert(pending_cmds.size(), random_cmd(n < 400 ? 90 : 45));
    end
    wait (n_checked >= n_total);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_views.size() == 0 && n_checked == n_total) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
rtl/lob_pkg.sv
rtl/lob_ctrl.sv
rtl/lob_datapath.sv
rtl/limit_order_book.sv
bench/tb.sv
